### hw/rtl/strided_pattern_search_defines.svh
// Assertion macros for the strided pattern search block.
// Every macro samples on clk and is disabled while rst is high.
`ifndef STRIDED_PATTERN_SEARCH_DEFINES_SVH
`define STRIDED_PATTERN_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("strided_pattern_search: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("strided_pattern_search: next-cycle check failed");

`endif

### hw/rtl/sps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the strided pattern search block.
// Used by strided_pattern_search; depends on nothing.
package sps_pkg;

  localparam int MAX_NEEDLE_BYTES  = 8;
  localparam int OFFSET_BITS       = 32;
  localparam int NEEDLE_BITS       = 64;
  localparam int LEN_BITS          = 4;
  localparam int STRIDE_BITS       = 8;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 64;
  localparam int BYTE_BITS         = 8;
  localparam int MATCH_OFFSET_BITS = 32;
  localparam int STATUS_BITS       = 2;
  localparam int WINDOW_BITS       = BYTE_BITS * MAX_NEEDLE_BYTES;
  localparam int MARK_IDX_BITS     = (MAX_NEEDLE_BYTES > 1) ? $clog2(MAX_NEEDLE_BYTES) : 1;
  localparam int IN_TDATA_BITS     = BYTE_BITS;
  localparam int RESULT_BITS       = STATUS_BITS + MATCH_OFFSET_BITS;
  localparam int OUT_TDATA_BITS    = ((RESULT_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE        = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEARCH_LAST   = 2'd3;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_FOUND      = 2'd0,
    STATUS_NOT_FOUND  = 2'd1,
    STATUS_BAD_CONFIG = 2'd2,
    STATUS_OVERFLOW   = 2'd3
  } status_t;

  // status sits in the low bits
  typedef struct packed {
    logic [MATCH_OFFSET_BITS-1:0] match_offset;
    status_t                      status;
  } result_t;

endpackage

### hw/rtl/strided_pattern_search.sv
`timescale 1ns / 1ps
// Strided pattern search: scans a byte stream for a configured needle at aligned starts.
// Depends on sps_pkg and strided_pattern_search_defines.svh.
//
//  channel | direction | beat holds
//  --------+-----------+------------------------------------------------
//  s_*     | in        | tdata: data_byte; tlast: end_of_haystack
//  m_*     | out       | tdata: status, match_offset (one beat per haystack)
//  cfg_*   | in        | register write: index, data; no read-back
//
// A byte is taken each cycle s_tready is high; the window compare is one registered pass.
// The result beat is shown in the cycle after the last byte is taken, unless an
// earlier result still waits, in which case it follows that one.
// A two-entry result buffer parts the sides: s_tready drops only while two results wait.
// Reset is synchronous; there is no clearing pass.
`include "strided_pattern_search_defines.svh"

module strided_pattern_search (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [sps_pkg::IN_TDATA_BITS-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                                   s_tlast,   // end_of_haystack
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [sps_pkg::OUT_TDATA_BITS-1:0]     m_tdata,   // [1:0] status, [33:2] match_offset
  input  logic                                   cfg_we,
  input  logic [sps_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [sps_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int MAXB = sps_pkg::MAX_NEEDLE_BYTES;
  localparam int BB   = sps_pkg::BYTE_BITS;

  // configuration
  logic [sps_pkg::NEEDLE_BITS-1:0] needle_bytes;
  logic [sps_pkg::LEN_BITS-1:0]    needle_length;
  logic [sps_pkg::STRIDE_BITS-1:0] stride;
  logic                            search_last;

  // search state
  logic [sps_pkg::WINDOW_BITS-1:0] window_bytes;
  logic [MAXB-1:0]                 aligned_start_marks;
  logic [sps_pkg::OFFSET_BITS-1:0] byte_position;
  logic [sps_pkg::STRIDE_BITS-1:0] stride_phase;
  logic                            have_match;
  logic [sps_pkg::OFFSET_BITS-1:0] best_offset;
  logic                            overflowed;

  // result buffer
  sps_pkg::result_t head;
  sps_pkg::result_t skid;
  logic             skid_valid;

  logic                            in_fire;
  logic                            push;
  logic                            pop;
  logic [sps_pkg::WINDOW_BITS-1:0] window_next;
  logic [MAXB-1:0]                 marks_next;
  logic [sps_pkg::STRIDE_BITS:0]   phase_inc;
  logic [sps_pkg::STRIDE_BITS-1:0] phase_next;
  logic [MAXB-1:0]                 len_match;
  logic                            len_ok;
  logic                            cfg_ok;
  logic [sps_pkg::LEN_BITS-1:0]    len_m1;
  logic [sps_pkg::MARK_IDX_BITS-1:0] len_idx;
  logic                            hit;
  logic [sps_pkg::OFFSET_BITS-1:0] cand_offset;
  logic                            have_match_next;
  logic [sps_pkg::OFFSET_BITS-1:0] best_offset_next;
  logic                            pos_full;
  logic                            overflowed_next;
  logic [sps_pkg::OFFSET_BITS-1:0] byte_position_next;
  sps_pkg::result_t                result;

  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign push     = in_fire && s_tlast;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = sps_pkg::OUT_TDATA_BITS'(head);

  always_comb begin
    window_next = (window_bytes << BB) | sps_pkg::WINDOW_BITS'(s_tdata[BB-1:0]);
    marks_next  = (aligned_start_marks << 1) | MAXB'(stride_phase == '0);
    phase_inc   = {1'b0, stride_phase} + (sps_pkg::STRIDE_BITS+1)'(1);
    phase_next  = (phase_inc >= {1'b0, stride}) ? '0 : phase_inc[sps_pkg::STRIDE_BITS-1:0];
  end

  // Candidate of length k+1 ends at the newest byte: needle byte i against window byte k-i.
  for (genvar k = 0; k < MAXB; k++) begin : g_len
    logic [MAXB-1:0] byte_ok;
    for (genvar i = 0; i < MAXB; i++) begin : g_byte
      if (i <= k) begin : g_cmp
        assign byte_ok[i] = (window_next[BB*(k-i) +: BB] == needle_bytes[BB*i +: BB]);
      end else begin : g_pad
        assign byte_ok[i] = 1'b1;
      end
    end
    assign len_match[k] = &byte_ok;
  end

  always_comb begin
    len_ok      = (needle_length != '0) && (needle_length <= sps_pkg::LEN_BITS'(MAXB));
    cfg_ok      = len_ok && (stride != '0);
    len_m1      = needle_length - sps_pkg::LEN_BITS'(1);
    len_idx     = len_m1[sps_pkg::MARK_IDX_BITS-1:0];
    cand_offset = byte_position - sps_pkg::OFFSET_BITS'(len_m1);
    hit = !overflowed && cfg_ok
          && (byte_position >= sps_pkg::OFFSET_BITS'(len_m1))
          && marks_next[len_idx] && len_match[len_idx];

    have_match_next  = have_match;
    best_offset_next = best_offset;
    if (hit && (!have_match || search_last)) begin
      have_match_next  = 1'b1;
      best_offset_next = cand_offset;
    end

    // counter sticks at all ones once the haystack outgrows it
    pos_full           = &byte_position;
    overflowed_next    = overflowed || pos_full;
    byte_position_next = pos_full ? byte_position
                                  : byte_position + sps_pkg::OFFSET_BITS'(1);

    result.match_offset = '0;
    if (!cfg_ok) begin
      result.status = sps_pkg::STATUS_BAD_CONFIG;
    end else if (overflowed_next) begin
      result.status = sps_pkg::STATUS_OVERFLOW;
    end else if (have_match_next) begin
      result.status       = sps_pkg::STATUS_FOUND;
      result.match_offset = sps_pkg::MATCH_OFFSET_BITS'(best_offset_next);
    end else begin
      result.status = sps_pkg::STATUS_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_bytes  <= '0;
      needle_length <= sps_pkg::LEN_BITS'(1);
      stride        <= sps_pkg::STRIDE_BITS'(1);
      search_last   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sps_pkg::REG_NEEDLE_BYTES:  needle_bytes  <= cfg_data[sps_pkg::NEEDLE_BITS-1:0];
        sps_pkg::REG_NEEDLE_LENGTH: needle_length <= cfg_data[sps_pkg::LEN_BITS-1:0];
        sps_pkg::REG_STRIDE:        stride        <= cfg_data[sps_pkg::STRIDE_BITS-1:0];
        sps_pkg::REG_SEARCH_LAST:   search_last   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      window_bytes        <= '0;
      aligned_start_marks <= '0;
      byte_position       <= '0;
      stride_phase        <= '0;
      have_match          <= 1'b0;
      best_offset         <= '0;
      overflowed          <= 1'b0;
    end else if (in_fire) begin
      window_bytes        <= window_next;
      aligned_start_marks <= marks_next;
      byte_position       <= byte_position_next;
      stride_phase        <= phase_next;
      have_match          <= have_match_next;
      best_offset         <= best_offset_next;
      overflowed          <= overflowed_next;
    end
  end

  // two-entry result queue: head drives m_tdata, skid catches a result while head is held
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || pop) begin
      if (skid_valid) begin
        head       <= skid;
        m_tvalid   <= 1'b1;
        skid_valid <= push;
        if (push) begin
          skid <= result;
        end
      end else begin
        m_tvalid <= push;
        if (push) begin
          head <= result;
        end
      end
    end else if (push) begin
      skid       <= result;
      skid_valid <= 1'b1;
    end
  end

  `SPS_ASSERT_SAME(a_skid_behind_head, skid_valid, m_tvalid)
  `SPS_ASSERT_NEXT(a_result_after_last, push, m_tvalid && byte_position == '0 && !have_match)
  `SPS_ASSERT_SAME(a_overflow_pins_count, overflowed, &byte_position)
  `SPS_ASSERT_SAME(a_offset_zero_unless_found, m_tvalid && head.status != sps_pkg::STATUS_FOUND, head.match_offset == '0)

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for strided_pattern_search: directed and random haystacks, checked beat by beat
// against a behavioural search predictor. Depends on sps_pkg and the block's RTL.
module tb;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_haystack;
  } hay_beat_t;

  typedef logic [7:0] hay_bytes_t[$];

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [sps_pkg::IN_TDATA_BITS-1:0]  s_tdata = '0;   // [7:0] data_byte
  logic                               s_tlast = 1'b0; // end_of_haystack
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [sps_pkg::OUT_TDATA_BITS-1:0] m_tdata;        // [1:0] status, [33:2] match_offset
  logic                               cfg_we = 1'b0;
  logic [sps_pkg::CFG_INDEX_BITS-1:0] cfg_index = sps_pkg::REG_NEEDLE_BYTES;
  logic [sps_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  hay_beat_t        pending_beats[$];
  sps_pkg::result_t expected_results[$];
  int               error_count = 0;
  int               send_idle_pct = 32;
  int               recv_idle_pct = 88;

  // register copies, reset values
  logic [63:0] cfg_needle = '0;
  logic [3:0]  cfg_len    = 4'd1;
  logic [7:0]  cfg_stride = 8'd1;
  logic        cfg_last   = 1'b0;

  // search state
  logic [63:0] hay_window   = '0;
  logic [7:0]  start_marks  = '0;
  logic [31:0] hay_pos      = '0;
  logic [7:0]  phase_count  = '0;
  logic        have_hit     = 1'b0;
  logic [31:0] hit_offset   = '0;
  logic        pos_overflow = 1'b0;

  strided_pattern_search u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // newest haystack byte sits in window bits 7..0, so needle byte 0 is the oldest
  function automatic logic needle_at_window(input int len);
    for (int i = 0; i < len; i++)
      if (hay_window[8*(len-1-i) +: 8] != cfg_needle[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic last);
    logic [31:0]      pos;
    int               len;
    logic             cfg_ok;
    sps_pkg::result_t res;
    pos = hay_pos;
    len = int'(cfg_len);
    cfg_ok = (len != 0) && (len <= sps_pkg::MAX_NEEDLE_BYTES) && (cfg_stride != 8'd0);
    hay_window  = {hay_window[55:0], b};
    start_marks = {start_marks[6:0], phase_count == 8'd0};
    phase_count = ({1'b0, phase_count} + 9'd1 >= {1'b0, cfg_stride}) ? 8'd0
                                                                      : phase_count + 8'd1;
    if (!pos_overflow && cfg_ok) begin
      if ({1'b0, pos} + 33'd1 >= 33'(len) && start_marks[len-1] && needle_at_window(len)
          && (!have_hit || cfg_last)) begin
        have_hit   = 1'b1;
        hit_offset = pos + 32'd1 - 32'(len);
      end
    end
    if (pos == '1) pos_overflow = 1'b1;
    else hay_pos = pos + 32'd1;
    if (last) begin
      res.match_offset = '0;
      if (!cfg_ok) res.status = sps_pkg::STATUS_BAD_CONFIG;
      else if (pos_overflow) res.status = sps_pkg::STATUS_OVERFLOW;
      else if (have_hit) begin
        res.status       = sps_pkg::STATUS_FOUND;
        res.match_offset = hit_offset;
      end else res.status = sps_pkg::STATUS_NOT_FOUND;
      expected_results.push_back(res);
      hay_window   = '0;
      start_marks  = '0;
      hay_pos      = '0;
      phase_count  = '0;
      have_hit     = 1'b0;
      hit_offset   = '0;
      pos_overflow = 1'b0;
    end
  endfunction

  // sender: predict on each accepted beat, then offer the next one or idle
  always @(posedge clk) begin : drive_bytes
    hay_beat_t next_beat;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) scan_byte(s_tdata[7:0], s_tlast);
      if (!s_tvalid || s_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_beat = pending_beats.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_beat.data_byte;
          s_tlast  <= next_beat.end_of_haystack;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    sps_pkg::result_t got;
    sps_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        got = sps_pkg::result_t'(m_tdata[sps_pkg::RESULT_BITS-1:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat: status %0d offset %0d",
                   $time, got.status, got.match_offset);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            error_count++;
          end
          if (got.match_offset !== want.match_offset) begin
            $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                     $time, want.match_offset, got.match_offset);
            error_count++;
          end
        end
      end
    end
  end

  task automatic push_haystack(input hay_bytes_t hay);
    hay_beat_t beat;
    foreach (hay[i]) begin
      beat.data_byte       = hay[i];
      beat.end_of_haystack = (i == hay.size() - 1);
      pending_beats.push_back(beat);
    end
  endtask

  // block idle: nothing queued or offered, every result back, then an extra slack wait
  task automatic settle();
    while (pending_beats.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] needle_w, input logic [63:0] len_w,
                            input logic [63:0] stride_w, input logic [63:0] last_w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sps_pkg::REG_NEEDLE_BYTES;
    cfg_data  <= needle_w;
    cfg_needle = needle_w;
    @(posedge clk);
    cfg_index <= sps_pkg::REG_NEEDLE_LENGTH;
    cfg_data  <= len_w;
    cfg_len    = len_w[3:0];
    @(posedge clk);
    cfg_index <= sps_pkg::REG_STRIDE;
    cfg_data  <= stride_w;
    cfg_stride = stride_w[7:0];
    @(posedge clk);
    cfg_index <= sps_pkg::REG_SEARCH_LAST;
    cfg_data  <= last_w;
    cfg_last   = last_w[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    hay_bytes_t  hay;
    logic [63:0] needle;
    logic [63:0] len_w;
    logic [63:0] stride_w;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;
    logic        two_sym;
    int          len;
    int          stride_val;
    int          hlen;
    int          nlen;
    int          p;
    int          r;
    int          items_sent;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset registers: single zero byte needle, first match
    hay = {8'hA5, 8'h00};
    push_haystack(hay);

    // full-length all-ones needle, last mode, then a haystack shorter than it
    settle();
    set_config({8{8'hFF}}, 64'd8, 64'd1, 64'd1);
    hay = {};
    repeat (9) hay.push_back(8'hFF);
    push_haystack(hay);
    hay = {8'hFF};
    push_haystack(hay);

    // bad configurations: zero length, length beyond the needle, zero stride
    settle();
    set_config(64'd0, 64'd0, 64'd1, 64'd0);
    hay = {8'h00};
    push_haystack(hay);
    settle();
    set_config(64'd0, 64'd15, 64'd1, 64'd0);
    hay = {8'hFF};
    push_haystack(hay);
    settle();
    set_config(64'd0, 64'd1, 64'd0, 64'd0);
    hay = {8'h00};
    push_haystack(hay);

    // widest stride: only offset 0 is a candidate
    settle();
    set_config(64'd0, 64'd1, 64'd255, 64'd0);
    hay = {8'h00, 8'h00};
    push_haystack(hay);

    // stride 2, last mode, repeated two-byte needle
    settle();
    set_config(64'hCDAB, 64'd2, 64'd2, 64'd1);
    hay = {8'hAB, 8'hCD, 8'hAB, 8'hCD, 8'hAB, 8'hCD};
    push_haystack(hay);

    items_sent = 0;
    while (items_sent < 1400) begin
      if (items_sent < 467) begin
        send_idle_pct = 32;
        recv_idle_pct = 88;
      end else if (items_sent < 933) begin
        send_idle_pct = 88;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      r = $urandom_range(99, 0);
      if (r < 4) len = 0;
      else if (r < 8) len = $urandom_range(15, 9);
      else if (r < 14) len = 8;
      else len = $urandom_range(8, 1);
      r = $urandom_range(99, 0);
      if (r < 4) stride_val = 0;
      else if (r < 8) stride_val = 255;
      else if (r < 16) stride_val = $urandom_range(254, 9);
      else stride_val = $urandom_range(8, 1);

      // a two-symbol alphabet makes chance matches common
      sym_a = 8'($urandom);
      sym_b = 8'($urandom);
      needle = {$urandom, $urandom};
      if ($urandom_range(3, 0) != 0)
        for (int i = 0; i < 8; i++) needle[8*i +: 8] = $urandom_range(1, 0) ? sym_a : sym_b;
      len_w = {$urandom, $urandom};
      len_w[3:0] = 4'(len);
      stride_w = {$urandom, $urandom};
      stride_w[7:0] = 8'(stride_val);

      settle();
      set_config(needle, len_w, stride_w, {$urandom, $urandom});

      repeat ($urandom_range(4, 1)) begin
        r = $urandom_range(99, 0);
        if (r < 70) hlen = $urandom_range(12, 1);
        else if (r < 95) hlen = $urandom_range(40, 13);
        else hlen = $urandom_range(100, 41);
        two_sym = ($urandom_range(4, 0) != 0);
        hay = {};
        for (int i = 0; i < hlen; i++)
          hay.push_back(two_sym ? ($urandom_range(1, 0) ? sym_a : sym_b) : 8'($urandom));
        nlen = (len >= 1 && len <= 8) ? len : 0;
        // plant copies of the needle, mostly at aligned starts
        if (nlen != 0 && nlen <= hlen && two_sym) begin
          repeat ($urandom_range(2, 0)) begin
            p = $urandom_range(hlen - nlen, 0);
            if (stride_val != 0 && $urandom_range(3, 0) != 0) p = p - p % stride_val;
            for (int i = 0; i < nlen; i++) hay[p+i] = needle[8*i +: 8];
          end
        end
        push_haystack(hay);
        items_sent += hlen;
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sps_pkg.sv
hw/rtl/strided_pattern_search.sv
tb/tb.sv
